// File: design/zccr_pkg.sv
// Shared constants and request types for the zero-cross chunk repitch block.
`timescale 1ns / 1ps

package zccr_pkg;

  // Store geometry; the depth is a power of two so indexes wrap by themselves
  localparam int STORE_DEPTH    = 2048;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int HALF_DEPTH     = STORE_DEPTH / 2;
  localparam int FILL_W         = ADDR_W + 1;

  // Sample and pitch-rate formats
  localparam int SAMPLE_BITS    = 16;
  localparam int RATE_FRAC_BITS = 12;
  localparam int POS_W          = ADDR_W + RATE_FRAC_BITS;

  // Crossing counter
  localparam int CNT_W          = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Read request: one pair of addresses per cycle
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } zccr_rd_req_t;

  // Write request
  typedef struct packed {
    logic                          en;
    logic [ADDR_W-1:0]             addr;
    logic signed [SAMPLE_BITS-1:0] data;
  } zccr_wr_req_t;

endpackage

// File: design/zccr_store.sv
// Circular sample store: one write port, two registered read ports, fill-count masking.
`timescale 1ns / 1ps

module zccr_store (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  zccr_pkg::zccr_rd_req_t                rd_req,
  input  zccr_pkg::zccr_wr_req_t                wr_req,
  output logic signed [zccr_pkg::SAMPLE_BITS-1:0] rd_a,
  output logic signed [zccr_pkg::SAMPLE_BITS-1:0] rd_b
);

  logic signed [zccr_pkg::SAMPLE_BITS-1:0] mem [zccr_pkg::STORE_DEPTH];
  logic signed [zccr_pkg::SAMPLE_BITS-1:0] mem_a_r;
  logic signed [zccr_pkg::SAMPLE_BITS-1:0] mem_b_r;
  logic                                    vld_a_r;
  logic                                    vld_b_r;
  logic                                    vld_a_nxt;
  logic                                    vld_b_nxt;
  logic [zccr_pkg::FILL_W-1:0]             fill_r;
  logic [zccr_pkg::FILL_W-1:0]             fill_nxt;
  logic [zccr_pkg::ADDR_W-1:0]             off_a;
  logic [zccr_pkg::ADDR_W-1:0]             off_b;

  // Writes run in order from the half-depth entry upward, so an entry holds
  // data once its distance from that entry is below the number of writes.
  always_comb begin
    off_a     = rd_req.addr_a - zccr_pkg::ADDR_W'(zccr_pkg::HALF_DEPTH);
    off_b     = rd_req.addr_b - zccr_pkg::ADDR_W'(zccr_pkg::HALF_DEPTH);
    vld_a_nxt = {1'b0, off_a} < fill_r;
    vld_b_nxt = {1'b0, off_b} < fill_r;
    fill_nxt  = fill_r;
    if (wr_req.en && (fill_r != zccr_pkg::FILL_W'(zccr_pkg::STORE_DEPTH))) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  // Count writes, saturating at the depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Memory array: one write, two reads with registered data
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
    if (rd_req.en) begin
      mem_a_r <= mem[rd_req.addr_a];
      mem_b_r <= mem[rd_req.addr_b];
      vld_a_r <= vld_a_nxt;
      vld_b_r <= vld_b_nxt;
    end
  end

  // Never-written entries read as zero
  assign rd_a = vld_a_r ? mem_a_r : '0;
  assign rd_b = vld_b_r ? mem_b_r : '0;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= zccr_pkg::FILL_W'(zccr_pkg::STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_req.en |=> $stable(fill_r))
    else $error("fill count moved without a write");

  a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_req.en && (fill_r != zccr_pkg::FILL_W'(zccr_pkg::STORE_DEPTH))
      |=> fill_r == $past(fill_r) + 1'b1)
    else $error("fill count missed a write");

endmodule

// File: design/zero_cross_chunk_repitch.sv
// Top level of the zero-cross chunk repitch block: request sequencer and datapath.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+-------------------------------------
//  in_      | in        | in_tvalid / in_tready  | in_tdata[39:0]: sample_in, pitch_rate,
//           |           |                        |   chunk_limit
//  out_     | out       | out_tvalid / out_tready| out_tdata[15:0]: sample_out
//
//  Each request runs through the engine states RD0, RD1, RD2 and UPD: three pairs
//  of store reads (old pitched position, new pitched position, unit read pointer)
//  on the store's two read ports, then UPD writes the sample and updates the state.
//  With the engine idle, an accepted request passes the holding register, then
//  RD0, RD1, RD2 and UPD, before out_tvalid rises; one request waits in a holding
//  register while the previous one runs, so a new request is accepted early.
//  Reset (rst_n low, synchronous) clears pointers, count and fill count; the
//  store is treated as zero until written, so no clearing pass is needed.
//  A stalled result holds the engine in its final cycle until it is taken.

module zero_cross_chunk_repitch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // sample_in[15:0], pitch_rate[31:16], chunk_limit[39:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // sample_out[15:0]
);

  localparam int SB = zccr_pkg::SAMPLE_BITS;
  localparam int F  = zccr_pkg::RATE_FRAC_BITS;
  localparam int SW = SB + F + 2;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_RD0  = 3'd1;
  localparam logic [2:0] PH_RD1  = 3'd2;
  localparam logic [2:0] PH_RD2  = 3'd3;
  localparam logic [2:0] PH_UPD  = 3'd4;

  // Holding register for the next request
  logic                          hold_v_r;
  logic [39:0]                   hold_r;

  // Working request
  logic signed [SB-1:0]          samp_r;
  logic [15:0]                   rate_r;
  logic [zccr_pkg::CNT_W-1:0]    limit_r;

  // Block state
  logic [2:0]                    phase_r;
  logic [2:0]                    phase_nxt;
  logic [zccr_pkg::POS_W-1:0]    pos_r;
  logic [zccr_pkg::POS_W-1:0]    pos_nxt;
  logic [zccr_pkg::ADDR_W-1:0]   rd_idx_r;
  logic [zccr_pkg::ADDR_W-1:0]   rd_idx_nxt;
  logic [zccr_pkg::CNT_W-1:0]    cnt_r;
  logic [zccr_pkg::CNT_W-1:0]    cnt_nxt;

  // Interpolated reads and output register
  logic signed [SB-1:0]          last_p_r;
  logic signed [SB-1:0]          cur_p_r;
  logic                          out_v_r;
  logic [15:0]                   out_d_r;
  logic [15:0]                   out_d_nxt;

  // Datapath
  logic [zccr_pkg::POS_W-1:0]    pos2;
  logic                          upd_go;
  logic                          start;
  logic                          active;
  logic                          p_cross;
  logic                          u_cross;
  logic [zccr_pkg::CNT_W-1:0]    cnt_a;
  logic [F-1:0]                  frac;
  logic signed [SB:0]            diff;
  logic signed [SW-1:0]          prod;
  logic signed [SW-1:0]          isum;
  logic signed [SW-1:0]          ishift;
  logic signed [SB-1:0]          interp;
  logic signed [SB-1:0]          rd_a;
  logic signed [SB-1:0]          rd_b;
  zccr_pkg::zccr_rd_req_t        rd_req;
  zccr_pkg::zccr_wr_req_t        wr_req;

  assign in_tready  = !hold_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // Advanced pitched position, wrapping at the store length
  assign pos2 = zccr_pkg::POS_W'({16'd0, pos_r} + {{zccr_pkg::POS_W{1'b0}}, rate_r});

  // Final cycle completes only when the output register can take the result
  assign upd_go = (phase_r == PH_UPD) && (!out_v_r || out_tready);
  assign start  = hold_v_r && ((phase_r == PH_IDLE) || upd_go);
  assign active = cnt_r < limit_r;

  // Read requests; the write happens only in the final cycle, so the next
  // request's reads always see it and no forwarding is needed
  always_comb begin
    rd_req = '0;
    case (phase_r)
      PH_RD0: begin
        rd_req.en     = 1'b1;
        rd_req.addr_a = pos_r[zccr_pkg::POS_W-1:F];
        rd_req.addr_b = pos_r[zccr_pkg::POS_W-1:F] + 1'b1;
      end
      PH_RD1: begin
        rd_req.en     = 1'b1;
        rd_req.addr_a = pos2[zccr_pkg::POS_W-1:F];
        rd_req.addr_b = pos2[zccr_pkg::POS_W-1:F] + 1'b1;
      end
      PH_RD2: begin
        rd_req.en     = 1'b1;
        rd_req.addr_a = rd_idx_r;
        rd_req.addr_b = rd_idx_r + 1'b1;
      end
      default: begin
        rd_req = '0;
      end
    endcase
  end

  // Write the sample half a store ahead of the unit read pointer
  always_comb begin
    wr_req.en   = upd_go;
    wr_req.addr = rd_idx_r + zccr_pkg::ADDR_W'(zccr_pkg::HALF_DEPTH);
    wr_req.data = samp_r;
  end

  zccr_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_req (rd_req),
    .wr_req (wr_req),
    .rd_a   (rd_a),
    .rd_b   (rd_b)
  );

  // Linear interpolation: a + ((b - a) * f + half) >> F, floored
  always_comb begin
    frac   = (phase_r == PH_RD1) ? pos_r[F-1:0] : pos2[F-1:0];
    diff   = {rd_b[SB-1], rd_b} - {rd_a[SB-1], rd_a};
    prod   = {{(SW-SB-1){diff[SB]}}, diff} * $signed({{(SW-F){1'b0}}, frac});
    isum   = ({{(SW-SB){rd_a[SB-1]}}, rd_a} <<< F) + prod
             + $signed(SW'(1) <<< (F - 1));
    ishift = isum >>> F;
    interp = ishift[SB-1:0];
  end

  // Crossing detection, count update and the silence decision
  always_comb begin
    p_cross = !cur_p_r[SB-1] && (cur_p_r != '0)
              && (last_p_r[SB-1] || (last_p_r == '0));
    u_cross = !rd_b[SB-1] && (rd_b != '0) && (rd_a[SB-1] || (rd_a == '0));
    cnt_a   = cnt_r;
    if (active && p_cross && (cnt_r != zccr_pkg::CNT_MAX)) begin
      cnt_a = cnt_r + 1'b1;
    end
    out_d_nxt = '0;
    if (active && (cnt_a < limit_r)) begin
      out_d_nxt = 16'(cur_p_r);
    end
    rd_idx_nxt = rd_idx_r + 1'b1;
    pos_nxt    = active ? pos2 : pos_r;
    cnt_nxt    = cnt_a;
    if (u_cross) begin
      pos_nxt = {rd_idx_nxt, {F{1'b0}}};
      cnt_nxt = '0;
    end
  end

  // Advance the sequencer
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          phase_nxt = PH_RD0;
        end
      end
      PH_RD0:  phase_nxt = PH_RD1;
      PH_RD1:  phase_nxt = PH_RD2;
      PH_RD2:  phase_nxt = PH_UPD;
      PH_UPD: begin
        if (upd_go) begin
          phase_nxt = start ? PH_RD0 : PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      pos_r    <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (in_tvalid && in_tready) begin
        hold_v_r <= 1'b1;
      end else if (start) begin
        hold_v_r <= 1'b0;
      end
      if (upd_go) begin
        out_v_r  <= 1'b1;
        pos_r    <= pos_nxt;
        rd_idx_r <= rd_idx_nxt;
        cnt_r    <= cnt_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_r <= in_tdata;
    end
    if (start) begin
      samp_r  <= hold_r[SB-1:0];
      rate_r  <= hold_r[31:16];
      limit_r <= hold_r[39:32];
    end
    if (phase_r == PH_RD1) begin
      last_p_r <= interp;
    end
    if (phase_r == PH_RD2) begin
      cur_p_r <= interp;
    end
    if (upd_go) begin
      out_d_r <= out_d_nxt;
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_req.en && wr_req.en))
    else $error("store read and write in the same cycle");

  a_read_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RD0) |=> (phase_r == PH_RD1) ##1 (phase_r == PH_RD2)
      ##1 (phase_r == PH_UPD))
    else $error("read phases out of order");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !upd_go |=> $stable(pos_r) && $stable(cnt_r) && $stable(rd_idx_r))
    else $error("pointer state changed outside the update cycle");

  a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) && hold_v_r |=> (phase_r == PH_RD0) && !hold_v_r
      || (phase_r == PH_RD0) && hold_v_r && $past(in_tvalid))
    else $error("waiting request not started");

endmodule
